>>> src/lrfb_pkg.sv
// Shared types, widths and codes of the LED ring frame buffer.
`default_nettype none

package lrfb_pkg;

  // Default number of ring cells
  localparam int MAX_RING_SIZE_DEF = 64;

  // Register and field widths
  localparam int RING_SIZE_W = 7;
  localparam int CAL_OFFSET_W = 6;
  localparam int REQ_W = 3;
  localparam int IDX_W = 8;
  localparam int CHAN_W = 8;
  localparam int AMOUNT_W = 8;
  localparam int PIXEL_W = 3 * CHAN_W;

  // Remainder dividend: pixel index plus calibration offset
  localparam int DIVIDEND_W = IDX_W + 1;

  // Port widths
  localparam int S_TDATA_W = IDX_W + 3 * CHAN_W + AMOUNT_W;
  localparam int M_TDATA_W = 3 * CHAN_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RING_SIZE_W;

  // Register reset values
  localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = RING_SIZE_W'(64);
  localparam logic [CAL_OFFSET_W-1:0] CAL_OFFSET_RST = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 1'b1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FILL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ROTL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ROTR = 3'd5;

  // One pixel: red 23..16, green 15..8, blue 7..0
  typedef logic [PIXEL_W-1:0] pixel_t;

  // Control broadcast to every ring cell
  typedef struct packed {
    logic   shift;
    pixel_t wrap;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/lrfb_cell.sv
// One ring cell: holds a pixel and takes its right neighbor on a shift.
`default_nettype none

module lrfb_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lrfb_pkg::cell_ctl_t ctl_i,
  input  wire logic [IW-1:0]      last_idx_i,
  input  wire lrfb_pkg::pixel_t   right_i,
  output lrfb_pkg::pixel_t        pix_o
);
  import lrfb_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  pixel_t pix_q, pix_d;
  logic   in_ring;
  logic   is_last;

  assign in_ring = (MY_IDX <= last_idx_i);
  assign is_last = (MY_IDX == last_idx_i);

  // Advance one slot left; the last ring cell takes the wrap value
  always_comb begin
    pix_d = pix_q;
    if (ctl_i.shift && in_ring) begin
      pix_d = is_last ? ctl_i.wrap : right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

>>> src/lrfb_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle.
`default_nettype none

module lrfb_mod #(
  parameter int NW = 7
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [lrfb_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [NW-1:0]                     divisor_i,
  output logic                                   done_o,
  output logic [NW-1:0]                          rem_o
);
  import lrfb_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [NW-1:0]         rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [NW:0]           trial;
  logic [NW:0]           div_ext;

  assign div_ext = {1'b0, divisor_i};
  assign trial   = {rem_q, dvd_q[DIVIDEND_W-1]};

  // Shift in the next bit and subtract the divisor when it fits
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVIDEND_W-2:0], 1'b0};
      rem_d = (trial >= div_ext) ? NW'(trial - div_ext) : NW'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> src/led_ring_frame_buffer_core.sv
// Top level of the LED ring frame buffer: request sequencer and ring of cells.
`default_nettype none

// Pixel store for an LED ring of up to MAX_RING_SIZE RGB pixels, held in a
// ring of cells that can only shift left by one slot per cycle, the value
// leaving slot 0 re-entering at slot n-1 (n is the ring size register,
// zero read as one and saturated at MAX_RING_SIZE). Every request returns
// one result, nonzero only for a read. A request first reduces its index
// or rotate amount modulo n in a bit-serial remainder unit, then shifts the
// ring: read, write, clear and fill make one full turn of n shifts (a read
// captures slot 0 on the way, a clear and a fill replace every wrapping
// value and a write only the one for its target), rotate left by k takes
// k shifts and rotate right by k takes n-k shifts, none for k zero. Only
// one request is in work at a time; the result sits in an output register
// so the next request is taken while it waits. Configuration writes are
// taken in any cycle and are meant for idle times.
module led_ring_frame_buffer_core #(
  parameter int MAX_RING_SIZE = lrfb_pkg::MAX_RING_SIZE_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Config write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lrfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lrfb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request stream
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  // tdata: pixel_index, red_in, green_in, blue_in, rotate_amount
  input  wire logic [lrfb_pkg::S_TDATA_W-1:0]    s_tdata_i,
  // tuser: req_type
  input  wire logic [lrfb_pkg::REQ_W-1:0]        s_tuser_i,
  // Result stream
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  // tdata: red_out, green_out, blue_out
  output logic [lrfb_pkg::M_TDATA_W-1:0]         m_tdata_o
);
  import lrfb_pkg::*;

  localparam int NW = $clog2(MAX_RING_SIZE + 1);
  localparam int IW = $clog2(MAX_RING_SIZE);
  localparam int CW = (NW > RING_SIZE_W) ? NW : RING_SIZE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOD   = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [RING_SIZE_W-1:0]  ring_size_q, ring_size_d;
  logic [CAL_OFFSET_W-1:0] cal_off_q, cal_off_d;
  logic [REQ_W-1:0]        req_q, req_d;
  pixel_t                  colour_q, colour_d;
  pixel_t                  res_q, res_d;
  pixel_t                  out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic [NW-1:0]           shift_q, shift_d;
  logic [NW-1:0]           tgt_q, tgt_d;

  logic [CW-1:0]           rs_ext;
  logic [NW-1:0]           n_eff;
  logic [IW-1:0]           last_idx;
  logic                    in_accept;
  logic                    cfg_accept;
  logic [DIVIDEND_W-1:0]   dividend;
  logic                    mod_done;
  logic [NW-1:0]           mod_rem;
  logic                    shift_en;
  cell_ctl_t               ctl;
  pixel_t                  pix [MAX_RING_SIZE];

  logic [IDX_W-1:0]        in_idx;
  logic [AMOUNT_W-1:0]     in_amount;
  pixel_t                  in_colour;

  assign in_idx    = s_tdata_i[IDX_W-1:0];
  assign in_colour = {s_tdata_i[IDX_W +: CHAN_W],
                      s_tdata_i[IDX_W + CHAN_W +: CHAN_W],
                      s_tdata_i[IDX_W + 2*CHAN_W +: CHAN_W]};
  assign in_amount = s_tdata_i[IDX_W + 3*CHAN_W +: AMOUNT_W];

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign in_accept   = s_tvalid_i && s_tready_o;

  // Effective ring size: zero reads as one, saturate at the cell count
  assign rs_ext = CW'(ring_size_q);
  always_comb begin
    priority if (rs_ext == '0) begin
      n_eff = NW'(1);
    end else if (rs_ext > CW'(MAX_RING_SIZE)) begin
      n_eff = NW'(MAX_RING_SIZE);
    end else begin
      n_eff = NW'(rs_ext);
    end
  end
  assign last_idx = IW'(n_eff - NW'(1));

  // Config register writes
  always_comb begin
    ring_size_d = ring_size_q;
    cal_off_d   = cal_off_q;
    if (cfg_accept) begin
      unique case (cfg_index_i)
        CFG_RING_SIZE:  ring_size_d = cfg_data_i;
        CFG_CAL_OFFSET: cal_off_d   = cfg_data_i[CAL_OFFSET_W-1:0];
        default:        ;
      endcase
    end
  end

  // Pick the value to reduce modulo the ring size
  always_comb begin
    priority if (s_tuser_i == REQ_WRITE) begin
      dividend = DIVIDEND_W'(in_idx) + DIVIDEND_W'(cal_off_q);
    end else if (s_tuser_i == REQ_READ) begin
      dividend = DIVIDEND_W'(in_idx);
    end else begin
      dividend = DIVIDEND_W'(in_amount);
    end
  end

  lrfb_mod #(
    .NW(NW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .dividend_i (dividend),
    .divisor_i  (n_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Value re-entering at the last ring slot
  always_comb begin
    ctl.shift = shift_en;
    priority if (req_q == REQ_CLEAR || req_q == REQ_FILL) begin
      ctl.wrap = colour_q;
    end else if (req_q == REQ_WRITE && cnt_q == tgt_q) begin
      ctl.wrap = colour_q;
    end else begin
      ctl.wrap = pix[0];
    end
  end

  // Ring of cells
  for (genvar gi = 0; gi < MAX_RING_SIZE; gi++) begin : g_cell
    localparam int NXT = (gi == MAX_RING_SIZE - 1) ? gi : gi + 1;
    lrfb_cell #(
      .IDX(gi),
      .IW (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .last_idx_i (last_idx),
      .right_i    (pix[NXT]),
      .pix_o      (pix[gi])
    );
  end

  // Request sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    colour_d    = colour_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    tgt_d       = tgt_q;
    shift_en    = 1'b0;

    // Drop the result once taken
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          req_d    = s_tuser_i;
          colour_d = (s_tuser_i == REQ_CLEAR) ? '0 : in_colour;
          res_d    = '0;
          state_d  = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          tgt_d = mod_rem;
          cnt_d = '0;
          priority if (req_q == REQ_WRITE || req_q == REQ_READ ||
                       req_q == REQ_CLEAR || req_q == REQ_FILL) begin
            shift_d = n_eff;
          end else if (req_q == REQ_ROTL) begin
            shift_d = mod_rem;
          end else if (req_q == REQ_ROTR) begin
            shift_d = (mod_rem == '0) ? '0 : n_eff - mod_rem;
          end else begin
            shift_d = '0;
          end
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt_q == shift_q) begin
          state_d = ST_DONE;
        end else begin
          shift_en = 1'b1;
          cnt_d    = cnt_q + NW'(1);
          if (req_q == REQ_READ && cnt_q == tgt_q) begin
            res_d = pix[0];
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_size_q <= RING_SIZE_RST;
      cal_off_q   <= CAL_OFFSET_RST;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      shift_q     <= '0;
    end else begin
      state_q     <= state_d;
      ring_size_q <= ring_size_d;
      cal_off_q   <= cal_off_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    colour_q <= colour_d;
    res_q    <= res_d;
    out_q    <= out_d;
    tgt_q    <= tgt_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_q[CHAN_W-1:0], out_q[CHAN_W +: CHAN_W],
                       out_q[2*CHAN_W +: CHAN_W]};

`ifndef SYNTH
  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_MOD))
    else $error("remainder finished outside the remainder phase");

  a_rem_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (mod_rem < n_eff))
    else $error("remainder not below ring size");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (cnt_q <= shift_q))
    else $error("shift counter passed its target");

  a_shift_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (shift_q <= n_eff))
    else $error("shift count exceeds one ring turn");

  a_accept_starts_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_MOD))
    else $error("accepted transaction did not start the remainder phase");
`endif

endmodule

`default_nettype wire
